>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/pofdt_pkg.sv
// package: position codes, register indexes and timer state type
package pofdt_pkg;

    localparam int unsigned POS_W    = 3;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PRESET_W = 31;

    localparam logic [POS_W-1:0] POS_OFF        = 3'd0;
    localparam logic [POS_W-1:0] POS_MOM_UP     = 3'd1;
    localparam logic [POS_W-1:0] POS_HELD_UP    = 3'd2;
    localparam logic [POS_W-1:0] POS_MOM_DOWN   = 3'd3;
    localparam logic [POS_W-1:0] POS_HELD_DOWN  = 3'd4;
    localparam logic [POS_W-1:0] POS_MOM_FLOAT  = 3'd5;
    localparam logic [POS_W-1:0] POS_HELD_FLOAT = 3'd6;
    localparam logic [POS_W-1:0] POS_INVALID    = 3'd7;

    localparam logic [1:0] REG_PRESET_UP    = 2'd0;
    localparam logic [1:0] REG_PRESET_DOWN  = 2'd1;
    localparam logic [1:0] REG_PRESET_FLOAT = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0]  cmd;
        logic [POS_W-1:0]  out;
        logic [TIME_W-1:0] start;
    } t_state;

endpackage

>>> rtl/four_position_off_delay_timer_top.sv
// off-delay timer for a three-direction switch: top level with apb presets
// usage
//   input channel (i_in_valid / o_in_ready) moves one transfer per scan tick:
//   an optional new commanded position and the current millisecond time
//   output channel (o_out_valid / i_out_ready) returns one transfer per
//   input transfer: output position, commanded position and elapsed time
//   a transfer taken lands in the input register, is stepped against the timer
//   state and is held in the result register that drives the output ports
//   throughput is one transfer per cycle unless the receiver stalls; the
//   combinational step (one 32-bit subtract, one preset compare and the
//   position decode) sets that figure
//   presets are written over apb at byte offsets 0 (up), 4 (down), 8 (float)
//   and should only change while no transfer is in flight
//   reset clears presets, commanded position, timer output and start time
//   when the receiver stalls the result holds, the input register keeps one
//   more transfer, and o_in_ready drops only once both stages are full
module four_position_off_delay_timer_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_load_request,
    input  logic [pofdt_pkg::POS_W-1:0]           i_request_position,
    input  logic signed [pofdt_pkg::TIME_W-1:0]   i_now_ms,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [pofdt_pkg::POS_W-1:0]           o_output_position,
    output logic [pofdt_pkg::POS_W-1:0]           o_command_position,
    output logic signed [pofdt_pkg::TIME_W-1:0]   o_elapsed_ms,
    // apb configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [3:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

`include "assert_macros.svh"

    // preset registers
    logic [pofdt_pkg::PRESET_W-1:0] r_preset_up;
    logic [pofdt_pkg::PRESET_W-1:0] r_preset_down;
    logic [pofdt_pkg::PRESET_W-1:0] r_preset_float;

    // input register
    logic                                 r_in_vld;
    logic                                 r_in_load;
    logic [pofdt_pkg::POS_W-1:0]          r_in_req;
    logic signed [pofdt_pkg::TIME_W-1:0]  r_in_now;

    // timer state
    pofdt_pkg::t_state r_state;
    pofdt_pkg::t_state n_state;

    // result register
    logic                                 r_out_vld;
    logic [pofdt_pkg::POS_W-1:0]          r_out_pos;
    logic [pofdt_pkg::POS_W-1:0]          r_out_cmd;
    logic signed [pofdt_pkg::TIME_W-1:0]  r_out_elapsed;
    logic signed [pofdt_pkg::TIME_W-1:0]  n_elapsed;

    logic in_xfer;
    logic advance;
    logic cfg_wr;

    // the step fires when the input register holds a transfer and the result register is free or being drained
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign o_out_valid        = r_out_vld;
    assign o_output_position  = r_out_pos;
    assign o_command_position = r_out_cmd;
    assign o_elapsed_ms       = r_out_elapsed;

    // apb: zero wait states, register index in paddr[3:2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            pofdt_pkg::REG_PRESET_UP:    prdata = {1'b0, r_preset_up};
            pofdt_pkg::REG_PRESET_DOWN:  prdata = {1'b0, r_preset_down};
            pofdt_pkg::REG_PRESET_FLOAT: prdata = {1'b0, r_preset_float};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset_up    <= '0;
            r_preset_down  <= '0;
            r_preset_float <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pofdt_pkg::REG_PRESET_UP:    r_preset_up    <= pwdata[pofdt_pkg::PRESET_W-1:0];
                pofdt_pkg::REG_PRESET_DOWN:  r_preset_down  <= pwdata[pofdt_pkg::PRESET_W-1:0];
                pofdt_pkg::REG_PRESET_FLOAT: r_preset_float <= pwdata[pofdt_pkg::PRESET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // step logic between input register and result register
    pofdt_step u_step (
        .i_state            (r_state),
        .i_load_request     (r_in_load),
        .i_request_position (r_in_req),
        .i_now_ms           (r_in_now),
        .i_preset_up_ms     (r_preset_up),
        .i_preset_down_ms   (r_preset_down),
        .i_preset_float_ms  (r_preset_float),
        .o_state            (n_state),
        .o_elapsed_ms       (n_elapsed)
    );

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (in_xfer) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_load <= i_load_request;
            r_in_req  <= i_request_position;
            r_in_now  <= i_now_ms;
        end
        if (advance) begin
            r_out_pos     <= n_state.out;
            r_out_cmd     <= n_state.cmd;
            r_out_elapsed <= n_elapsed;
        end
    end

    // checks
    `ASSERT_IMPLIES(a_cmd_never_invalid, i_clk, i_rst_n, 1'b1,
        r_state.cmd != pofdt_pkg::POS_INVALID)
    `ASSERT_IMPLIES(a_out_pos_legal, i_clk, i_rst_n, o_out_valid,
        o_output_position != pofdt_pkg::POS_INVALID)
    `ASSERT_NEXT(a_step_gives_result, i_clk, i_rst_n, advance, o_out_valid)
    `ASSERT_NEXT(a_accept_fills_input, i_clk, i_rst_n, in_xfer, r_in_vld)

endmodule

>>> rtl/pofdt_step.sv
// one timer step: next state and elapsed time from the current state and one item
module pofdt_step (
    input  pofdt_pkg::t_state                         i_state,
    input  logic                                      i_load_request,
    input  logic [pofdt_pkg::POS_W-1:0]               i_request_position,
    input  logic signed [pofdt_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [pofdt_pkg::PRESET_W-1:0]            i_preset_up_ms,
    input  logic [pofdt_pkg::PRESET_W-1:0]            i_preset_down_ms,
    input  logic [pofdt_pkg::PRESET_W-1:0]            i_preset_float_ms,
    output pofdt_pkg::t_state                         o_state,
    output logic signed [pofdt_pkg::TIME_W-1:0]       o_elapsed_ms
);

    logic [pofdt_pkg::POS_W-1:0]    cmd;
    logic [pofdt_pkg::TIME_W-1:0]   elapsed;
    logic [pofdt_pkg::PRESET_W-1:0] preset_sel;
    logic                           reached;

    assign cmd          = i_load_request ? i_request_position : i_state.cmd;
    assign elapsed      = i_now_ms - i_state.start;
    assign o_elapsed_ms = elapsed;

    // preset of the direction the output currently drives
    always_comb begin
        case (i_state.out) inside
            pofdt_pkg::POS_MOM_UP, pofdt_pkg::POS_HELD_UP: begin
                preset_sel = i_preset_up_ms;
            end
            pofdt_pkg::POS_MOM_DOWN, pofdt_pkg::POS_HELD_DOWN: begin
                preset_sel = i_preset_down_ms;
            end
            default: begin
                preset_sel = i_preset_float_ms;
            end
        endcase
    end

    // negative elapsed never reaches a preset
    assign reached = !elapsed[pofdt_pkg::TIME_W-1]
                     && (elapsed[pofdt_pkg::PRESET_W-1:0] >= preset_sel);

    always_comb begin
        o_state       = i_state;
        o_state.cmd   = cmd;
        case (cmd) inside
            pofdt_pkg::POS_OFF: begin
                case (i_state.out) inside
                    pofdt_pkg::POS_MOM_UP, pofdt_pkg::POS_HELD_UP,
                    pofdt_pkg::POS_MOM_DOWN, pofdt_pkg::POS_HELD_DOWN,
                    pofdt_pkg::POS_MOM_FLOAT, pofdt_pkg::POS_HELD_FLOAT: begin
                        if (reached) begin
                            o_state.out = pofdt_pkg::POS_OFF;
                        end
                    end
                    default: begin
                        o_state.out = pofdt_pkg::POS_OFF;
                    end
                endcase
            end
            pofdt_pkg::POS_MOM_UP, pofdt_pkg::POS_MOM_DOWN, pofdt_pkg::POS_MOM_FLOAT: begin
                if (i_state.out != pofdt_pkg::POS_OFF) begin
                    // second press cancels
                    o_state.out = pofdt_pkg::POS_OFF;
                    o_state.cmd = pofdt_pkg::POS_OFF;
                end else begin
                    o_state.start = i_now_ms;
                    o_state.out   = cmd;
                end
            end
            pofdt_pkg::POS_HELD_UP, pofdt_pkg::POS_HELD_DOWN, pofdt_pkg::POS_HELD_FLOAT: begin
                if (i_state.out == cmd - 3'd1) begin
                    o_state.out = cmd;
                end
            end
            default: begin
                o_state.out = pofdt_pkg::POS_OFF;
                o_state.cmd = pofdt_pkg::POS_OFF;
            end
        endcase
    end

endmodule
